@@ sv/pbm_pkg.sv @@
`default_nettype none
package pbm_pkg;

  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_INDEX_BITS   = 24;

  // packed channel lanes in the offset and width registers
  localparam int LANES     = 4;
  localparam int LANE_BITS = 8;

  localparam int MEM_BIT_W  = 33;
  localparam int CH_NUM_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int WSL_W      = 3;
  localparam int BOM_W      = 4;
  localparam int PIX_BITS_W = 9;
  localparam int CH_CNT_W   = 3;
  localparam int OFFPOS_W   = LANE_BITS + 1;

  localparam logic [WSL_W-1:0] MAX_WORD_LOG2 = 3'd4;

  localparam logic [WSL_W-1:0]      RST_WORD_SIZE_LOG2  = 3'd0;
  localparam logic [BOM_W-1:0]      RST_BYTE_ORDER_MASK = 4'd0;
  localparam logic                  RST_MSB_FIRST       = 1'b0;
  localparam logic [PIX_BITS_W-1:0] RST_PIXEL_BITS      = 9'd7;
  localparam logic [CH_CNT_W-1:0]   RST_CHANNEL_COUNT   = 3'd1;
  localparam logic [CFG_DATA_W-1:0] RST_CHANNEL_OFFSETS = 32'd5;
  localparam logic [CFG_DATA_W-1:0] RST_CHANNEL_WIDTHS  = 32'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD_SIZE_LOG2  = 3'd0,
    REG_BYTE_ORDER_MASK = 3'd1,
    REG_MSB_FIRST       = 3'd2,
    REG_PIXEL_BITS      = 3'd3,
    REG_CHANNEL_COUNT   = 3'd4,
    REG_CHANNEL_OFFSETS = 3'd5,
    REG_CHANNEL_WIDTHS  = 3'd6
  } cfg_reg_e;

endpackage
`default_nettype wire

@@ sv/pbm_if.sv @@
`default_nettype none
interface pbm_in_if #(
  parameter int INDEX_BITS = pbm_pkg::DEF_INDEX_BITS
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] used_bit;

  modport source (output valid, output used_bit, input ready);
  modport sink   (input valid, input used_bit, output ready);
endinterface

interface pbm_out_if #(
  parameter int INDEX_BITS = pbm_pkg::DEF_INDEX_BITS
);
  import pbm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MEM_BIT_W-1:0]  memory_bit;
  logic [INDEX_BITS-1:0] pixel_number;
  logic [CH_NUM_W-1:0]   channel_number;

  modport source (output valid, output memory_bit, output pixel_number,
                  output channel_number, input ready);
  modport sink   (input valid, input memory_bit, input pixel_number,
                  input channel_number, output ready);
endinterface

interface pbm_cfg_if;
  import pbm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ sv/pixel_bit_to_memory_bit_mapper.sv @@
`default_nettype none
// Maps the index of a channel bit in a packed pixel stream to its bit
// address in byte memory.
// Channels: in_i carries used_bit requests, out_o carries memory_bit,
// pixel_number and channel_number, both valid/ready. cfg_i writes one of
// the seven layout registers by index; it is always ready. The user must write
// it only while no request is in flight; the block itself does not enforce this.
// One request is taken every cycle while no result waits on a stalled
// receiver. The division by the summed channel widths is done as a
// pipeline of INDEX_BITS compare-subtract stages, followed by a channel
// scan stage, a multiply stage and the word mapping stage.
// Reset clears all valid bits and loads the register reset layout.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_i.ready drops; nothing is lost or repeated. Results leave in
// request order.
module pixel_bit_to_memory_bit_mapper #(
  parameter int MAX_CHANNELS = pbm_pkg::DEF_MAX_CHANNELS,
  parameter int INDEX_BITS   = pbm_pkg::DEF_INDEX_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pbm_in_if.sink     in_i,
  pbm_out_if.source  out_o,
  pbm_cfg_if.sink    cfg_i
);
  import pbm_pkg::*;

  localparam int TOTAL_W = $clog2(MAX_CHANNELS * ((1 << LANE_BITS) - 1) + 1);
  localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int PROD_W  = INDEX_BITS + PIX_BITS_W;

  // configuration registers
  logic [WSL_W-1:0]      wsl_q;
  logic [BOM_W-1:0]      bom_q;
  logic                  msb_q;
  logic [PIX_BITS_W-1:0] pix_bits_q;
  logic [CH_CNT_W-1:0]   ch_cnt_q;
  logic [CFG_DATA_W-1:0] ch_off_q;
  logic [CFG_DATA_W-1:0] ch_wid_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsl_q      <= RST_WORD_SIZE_LOG2;
      bom_q      <= RST_BYTE_ORDER_MASK;
      msb_q      <= RST_MSB_FIRST;
      pix_bits_q <= RST_PIXEL_BITS;
      ch_cnt_q   <= RST_CHANNEL_COUNT;
      ch_off_q   <= RST_CHANNEL_OFFSETS;
      ch_wid_q   <= RST_CHANNEL_WIDTHS;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_WORD_SIZE_LOG2:  wsl_q      <= cfg_i.data[WSL_W-1:0];
        REG_BYTE_ORDER_MASK: bom_q      <= cfg_i.data[BOM_W-1:0];
        REG_MSB_FIRST:       msb_q      <= cfg_i.data[0];
        REG_PIXEL_BITS:      pix_bits_q <= cfg_i.data[PIX_BITS_W-1:0];
        REG_CHANNEL_COUNT:   ch_cnt_q   <= cfg_i.data[CH_CNT_W-1:0];
        REG_CHANNEL_OFFSETS: ch_off_q   <= cfg_i.data;
        REG_CHANNEL_WIDTHS:  ch_wid_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // layout derived from the registers
  logic [CNT_W-1:0]     n_eff;
  logic [LANE_BITS-1:0] ch_w     [MAX_CHANNELS];
  logic [TOTAL_W-1:0]   ch_start [MAX_CHANNELS];
  logic [TOTAL_W-1:0]   ch_end   [MAX_CHANNELS];
  logic [TOTAL_W-1:0]   total;

  always_comb begin
    if (ch_cnt_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(ch_cnt_q) > MAX_CHANNELS) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = CNT_W'(ch_cnt_q);
    end
  end

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    if (i < LANES) begin : g_real
      assign ch_w[i] = (i < int'(n_eff)) ? ch_wid_q[LANE_BITS*i +: LANE_BITS] : '0;
    end else begin : g_none
      assign ch_w[i] = '0;
    end
    if (i == 0) begin : g_first
      assign ch_start[i] = '0;
    end else begin : g_next
      assign ch_start[i] = ch_end[i-1];
    end
    assign ch_end[i] = TOTAL_W'(ch_start[i] + TOTAL_W'(ch_w[i]));
  end

  assign total = ch_end[MAX_CHANNELS-1];

  // pipeline advance: the whole pipe holds while a result waits
  logic adv;
  logic out_vld_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  logic                  div_vld;
  logic [INDEX_BITS-1:0] div_quo;
  logic [TOTAL_W-1:0]    div_rem;

  pbm_divider #(
    .INDEX_BITS (INDEX_BITS),
    .TOTAL_W    (TOTAL_W)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (in_i.valid),
    .dividend_i  (in_i.used_bit),
    .divisor_i   (total),
    .valid_o     (div_vld),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // channel scan stage
  logic [CH_NUM_W-1:0]   ch_sel;
  logic [TOTAL_W-1:0]    base_sel;
  logic [LANE_BITS-1:0]  w_sel;
  logic [LANE_BITS-1:0]  cbit;
  logic [LANE_BITS-1:0]  pos;
  logic [LANE_BITS-1:0]  off_sel;
  logic                  total_zero;
  logic [INDEX_BITS-1:0] pix_d;
  logic [CH_NUM_W-1:0]   ch_d;
  logic [OFFPOS_W-1:0]   offpos_d;

  always_comb begin
    ch_sel   = '0;
    base_sel = '0;
    w_sel    = ch_w[0];
    // widths only grow the end marks, so the lowest hit is the channel
    for (int i = MAX_CHANNELS - 1; i >= 0; i--) begin
      if (div_rem < ch_end[i]) begin
        ch_sel   = CH_NUM_W'(i);
        base_sel = ch_start[i];
        w_sel    = ch_w[i];
      end
    end
  end

  assign total_zero = (total == '0);
  assign cbit       = total_zero ? '0 : LANE_BITS'(div_rem - base_sel);
  assign pos        = (msb_q && !total_zero) ? LANE_BITS'(w_sel - cbit - 1'b1) : cbit;
  assign ch_d       = total_zero ? '0 : ch_sel;
  assign pix_d      = total_zero ? '0 : div_quo;
  assign off_sel    = ch_off_q[LANE_BITS*ch_d +: LANE_BITS];
  assign offpos_d   = OFFPOS_W'(off_sel) + OFFPOS_W'(pos);

  logic                  vld_s_q;
  logic [INDEX_BITS-1:0] pix_s_q;
  logic [CH_NUM_W-1:0]   ch_s_q;
  logic [OFFPOS_W-1:0]   offpos_s_q;

  // multiply stage
  logic [PROD_W-1:0]     prod_full;
  logic                  vld_m_q;
  logic [INDEX_BITS-1:0] pix_m_q;
  logic [CH_NUM_W-1:0]   ch_m_q;
  logic [OFFPOS_W-1:0]   offpos_m_q;
  logic [MEM_BIT_W-1:0]  prod_m_q;

  assign prod_full = PROD_W'(pix_s_q) * PROD_W'(pix_bits_q);

  // word mapping stage
  logic [WSL_W-1:0]      lg;
  logic [7:0]            bpw;
  logic [4:0]            bytes;
  logic [BOM_W-1:0]      emask;
  logic [6:0]            flip;
  logic [MEM_BIT_W-1:0]  strip;
  logic [MEM_BIT_W-1:0]  mem_d;

  assign lg    = (wsl_q > MAX_WORD_LOG2) ? MAX_WORD_LOG2 : wsl_q;
  assign bpw   = 8'd8 << lg;
  assign bytes = 5'd1 << lg;
  assign emask = bom_q & BOM_W'(bytes - 5'd1);
  // msb-first reverses the bit inside the word, the mask swaps bytes
  assign flip  = (msb_q ? 7'(bpw - 8'd1) : 7'd0) ^ {emask, 3'b000};
  assign strip = prod_m_q + MEM_BIT_W'(offpos_m_q);
  assign mem_d = strip ^ MEM_BIT_W'(flip);

  logic [MEM_BIT_W-1:0]  out_mem_q;
  logic [INDEX_BITS-1:0] out_pix_q;
  logic [CH_NUM_W-1:0]   out_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q   <= 1'b0;
      vld_m_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_s_q   <= div_vld;
      vld_m_q   <= vld_s_q;
      out_vld_q <= vld_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_s_q    <= pix_d;
      ch_s_q     <= ch_d;
      offpos_s_q <= offpos_d;
      pix_m_q    <= pix_s_q;
      ch_m_q     <= ch_s_q;
      offpos_m_q <= offpos_s_q;
      prod_m_q   <= MEM_BIT_W'(prod_full);
      out_mem_q  <= mem_d;
      out_pix_q  <= pix_m_q;
      out_ch_q   <= ch_m_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.memory_bit     = out_mem_q;
  assign out_o.pixel_number   = out_pix_q;
  assign out_o.channel_number = out_ch_q;

endmodule
`default_nettype wire

@@ sv/pbm_divider.sv @@
`default_nettype none
module pbm_divider #(
  parameter int INDEX_BITS = 24,
  parameter int TOTAL_W    = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  adv_i,
  input  wire logic                  valid_i,
  input  wire logic [INDEX_BITS-1:0] dividend_i,
  input  wire logic [TOTAL_W-1:0]    divisor_i,
  output logic                       valid_o,
  output logic [INDEX_BITS-1:0]      quotient_o,
  output logic [TOTAL_W-1:0]         remainder_o
);

  // restoring division, one quotient bit per stage
  logic [INDEX_BITS-1:0] vld_q;
  logic [TOTAL_W-1:0]    rem_q [INDEX_BITS];
  logic [INDEX_BITS-1:0] dq_q  [INDEX_BITS];

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_step
    logic [TOTAL_W-1:0]    rem_in;
    logic [INDEX_BITS-1:0] dq_in;
    logic                  vld_in;
    logic [TOTAL_W:0]      trial;
    logic                  ge;
    logic [TOTAL_W-1:0]    rem_d;
    logic [INDEX_BITS-1:0] dq_d;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // dq holds the remaining dividend bits on top and quotient bits below
    assign trial = {rem_in, dq_in[INDEX_BITS-1]};
    assign ge    = trial >= {1'b0, divisor_i};
    assign rem_d = ge ? TOTAL_W'(trial - {1'b0, divisor_i}) : trial[TOTAL_W-1:0];
    assign dq_d  = {dq_in[INDEX_BITS-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= rem_d;
        dq_q[k]  <= dq_d;
      end
    end
  end

  assign valid_o     = vld_q[INDEX_BITS-1];
  assign quotient_o  = dq_q[INDEX_BITS-1];
  assign remainder_o = rem_q[INDEX_BITS-1];

endmodule
`default_nettype wire

@@ sv/pbm_checker.sv @@
`default_nettype none
module pbm_checker #(
  parameter int INDEX_BITS = pbm_pkg::DEF_INDEX_BITS
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_ready_i,
  input wire logic                            out_valid_i,
  input wire logic                            out_ready_i,
  input wire logic [pbm_pkg::MEM_BIT_W-1:0]   memory_bit_i,
  input wire logic [INDEX_BITS-1:0]           pixel_number_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(memory_bit_i) && $stable(pixel_number_i))
    else $error("stalled result changed");

  // an empty output slot never blocks new requests
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with output free");

  // a waiting result must hold the pipeline
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

endmodule

bind pixel_bit_to_memory_bit_mapper pbm_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_pbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .memory_bit_i   (out_o.memory_bit),
  .pixel_number_i (out_o.pixel_number)
);
`default_nettype wire
